// ===== rtl/iafp_pkg.sv =====
// ----------------------------------------------------------------------------
// iafp_pkg
// Types and constants shared by the attitude frame parser.
// ----------------------------------------------------------------------------
package iafp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ANGLE_W   = 22;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned PAY_DEPTH = 5;
  localparam int unsigned PAY_IDX_W = 3;
  localparam int unsigned FRAME_PAY = 6;

  localparam logic [BYTE_W-1:0] HDR_SYNC = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_ID   = 8'h01;
  localparam logic [BYTE_W-1:0] HDR_LEN  = 8'h06;

  // (raw + 32768) * 45 == raw * 45 + 1474560
  localparam logic [5:0] ANGLE_SCALE = 6'd45;

  typedef enum logic [3:0] {
    PH_HDR0 = 4'd0,
    PH_HDR1 = 4'd1,
    PH_HDR2 = 4'd2,
    PH_HDR3 = 4'd3,
    PH_PAY0 = 4'd4,
    PH_PAY1 = 4'd5,
    PH_PAY2 = 4'd6,
    PH_PAY3 = 4'd7,
    PH_PAY4 = 4'd8,
    PH_LAST = 4'd9
  } phase_t;

  typedef struct packed {
    logic                           done;
    logic [FRAME_PAY-1:0][BYTE_W-1:0] payload;
  } frame_t;

endpackage

// ===== rtl/iafp_ifs.sv =====
// ----------------------------------------------------------------------------
// iafp interfaces
// Byte input channel and angle result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iafp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface iafp_angle_if;
  logic        valid;
  logic        ready;
  logic [21:0] roll_angle;
  logic [21:0] pitch_angle;
  logic [21:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, output ready);
endinterface

// ===== rtl/iafp_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// iafp_frame_fsm
// Header sync and payload capture; flags a complete frame on its last byte.
// ----------------------------------------------------------------------------
module iafp_frame_fsm
  import iafp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] byte_in,
  output frame_t            frame
);

  phase_t                phase;
  phase_t                phase_next;
  logic [BYTE_W-1:0]     store [PAY_DEPTH];
  logic                  wr_en;
  logic [PAY_IDX_W-1:0]  wr_idx;
  logic                  frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      store[wr_idx] <= byte_in;
    end
  end

  always_comb begin
    case (phase)
      PH_HDR0: phase_next = (byte_in == HDR_SYNC) ? PH_HDR1 : PH_HDR0;
      PH_HDR1: phase_next = (byte_in == HDR_SYNC) ? PH_HDR2 : PH_HDR0;
      PH_HDR2: phase_next = (byte_in == HDR_ID)   ? PH_HDR3 : PH_HDR0;
      PH_HDR3: phase_next = (byte_in == HDR_LEN)  ? PH_PAY0 : PH_HDR0;
      PH_PAY0: phase_next = PH_PAY1;
      PH_PAY1: phase_next = PH_PAY2;
      PH_PAY2: phase_next = PH_PAY3;
      PH_PAY3: phase_next = PH_PAY4;
      PH_PAY4: phase_next = PH_LAST;
      default: phase_next = PH_HDR0;
    endcase
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = '0;
    frame_done = 1'b0;
    case (phase)
      PH_PAY0: begin wr_en = 1'b1; wr_idx = PAY_IDX_W'(0); end
      PH_PAY1: begin wr_en = 1'b1; wr_idx = PAY_IDX_W'(1); end
      PH_PAY2: begin wr_en = 1'b1; wr_idx = PAY_IDX_W'(2); end
      PH_PAY3: begin wr_en = 1'b1; wr_idx = PAY_IDX_W'(3); end
      PH_PAY4: begin wr_en = 1'b1; wr_idx = PAY_IDX_W'(4); end
      PH_LAST: frame_done = step;
      default: wr_en = 1'b0;
    endcase
  end

  assign frame.done       = frame_done;
  assign frame.payload[0] = store[0];
  assign frame.payload[1] = store[1];
  assign frame.payload[2] = store[2];
  assign frame.payload[3] = store[3];
  assign frame.payload[4] = store[4];
  assign frame.payload[5] = byte_in;

endmodule

// ===== rtl/iafp_angle_out.sv =====
// ----------------------------------------------------------------------------
// iafp_angle_out
// Scales raw int16 angles to 1/8192 degree and holds the result transaction.
// ----------------------------------------------------------------------------
module iafp_angle_out
  import iafp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  frame_t frame,
  output logic   busy,
  iafp_angle_if.source out_ch
);

  logic out_vld;

  function automatic logic [ANGLE_W-1:0] scale(input logic [BYTE_W-1:0] lo,
                                               input logic [BYTE_W-1:0] hi);
    logic [RAW_W-1:0] biased;
    biased = {~hi[7], hi[6:0], lo};
    return ANGLE_W'(biased) * ANGLE_W'(ANGLE_SCALE);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (frame.done) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      out_ch.roll_angle  <= scale(frame.payload[0], frame.payload[1]);
      out_ch.pitch_angle <= scale(frame.payload[2], frame.payload[3]);
      out_ch.yaw_angle   <= scale(frame.payload[4], frame.payload[5]);
    end
  end

  assign out_ch.valid = out_vld;
  assign busy         = out_vld && !out_ch.ready;

endmodule

// ===== rtl/imu_attitude_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// imu_attitude_frame_parser_top
// Path: a frame's tenth byte reaches its result through the input register
// and then the result register. Throughput: one byte per cycle, limited only
// by the result register when a result waits to be taken.
// Reset: synchronous; parser returns to hunting the first header byte and
// both registers empty. Payload store is not cleared.
// ----------------------------------------------------------------------------
module imu_attitude_frame_parser_top
  import iafp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  iafp_byte_if.sink    in_ch,
  iafp_angle_if.source out_ch
);

  logic              byte_vld;
  logic [BYTE_W-1:0] byte_q;
  logic              out_busy;
  logic              advance;
  frame_t            frame;

  assign advance     = byte_vld && !out_busy;
  assign in_ch.ready = !byte_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (in_ch.ready) begin
      byte_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_q <= in_ch.rx_byte;
    end
  end

  iafp_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (byte_q),
    .frame   (frame)
  );

  iafp_angle_out u_out (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame),
    .busy   (out_busy),
    .out_ch (out_ch)
  );

endmodule
